// ===== src/u8u16_pkg.sv =====
package u8u16_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned CpW     = 21;
  localparam int unsigned MaxBeats = 4;
  localparam int unsigned IdxW    = $clog2(MaxBeats);

  localparam logic [CpW-1:0] CpBmpMax  = 21'h00FFFF;
  localparam logic [CpW-1:0] CpMax     = 21'h10FFFF;
  localparam logic [CpW-1:0] CpSuppBase = 21'h010000;
  localparam logic [5:0]     HiSurPfx  = 6'b110110;  // 0xD800 >> 10
  localparam logic [5:0]     LoSurPfx  = 6'b110111;  // 0xDC00 >> 10

  // up to four output beats produced by one input byte
  typedef struct packed {
    logic [MaxBeats-1:0][ByteW-1:0] data;
    logic [IdxW-1:0]                last_idx;
    logic                           status;
    logic                           done;
  } burst_t;

endpackage

// ===== src/u8u16_decode.sv =====
module u8u16_decode
  import u8u16_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [ByteW-1:0] byte_i,
  input  logic             end_i,
  output logic             has_result_o,
  output burst_t           burst_o
);

  logic [1:0]     pend_q, pend_d;
  logic [CpW-1:0] acc_q, acc_d;
  logic           drop_q, drop_d;

  logic [CpW-1:0] acc_ext;
  logic [CpW-1:0] supp;
  logic [1:0]     pend_dec;

  assign acc_ext  = {acc_q[CpW-7:0], byte_i[5:0]};
  assign pend_dec = pend_q - 2'd1;
  assign supp     = acc_ext - CpSuppBase;

  always_comb begin
    pend_d       = pend_q;
    acc_d        = acc_q;
    drop_d       = drop_q;
    has_result_o = 1'b0;
    burst_o      = '0;

    if (drop_q) begin
      if (end_i) begin
        drop_d = 1'b0;
        pend_d = 2'd0;
        acc_d  = '0;
      end
    end else if (pend_q == 2'd0) begin
      if (!byte_i[7]) begin
        has_result_o     = 1'b1;
        burst_o.data[0]  = '0;
        burst_o.data[1]  = byte_i;
        burst_o.last_idx = IdxW'(1);
        burst_o.done     = end_i;
      end else if (byte_i[7:5] == 3'b110 || byte_i[7:4] == 4'b1110 ||
                   byte_i[7:3] == 5'b11110) begin
        if (end_i) begin
          // string ends right after a lead byte
          has_result_o   = 1'b1;
          burst_o.status = 1'b1;
          burst_o.done   = 1'b1;
          pend_d         = 2'd0;
          acc_d          = '0;
        end else if (byte_i[5] == 1'b0) begin
          acc_d  = CpW'(byte_i[4:0]);
          pend_d = 2'd1;
        end else if (byte_i[4] == 1'b0) begin
          acc_d  = CpW'(byte_i[3:0]);
          pend_d = 2'd2;
        end else begin
          acc_d  = CpW'(byte_i[2:0]);
          pend_d = 2'd3;
        end
      end else begin
        has_result_o   = 1'b1;
        burst_o.status = 1'b1;
        burst_o.done   = 1'b1;
        drop_d         = !end_i;
      end
    end else begin
      if (byte_i[7:6] != 2'b10) begin
        has_result_o   = 1'b1;
        burst_o.status = 1'b1;
        burst_o.done   = 1'b1;
        drop_d         = !end_i;
        pend_d         = 2'd0;
        acc_d          = '0;
      end else if (pend_dec == 2'd0) begin
        pend_d       = 2'd0;
        acc_d        = '0;
        has_result_o = 1'b1;
        if (acc_ext <= CpBmpMax) begin
          burst_o.data[0]  = acc_ext[15:8];
          burst_o.data[1]  = acc_ext[7:0];
          burst_o.last_idx = IdxW'(1);
          burst_o.done     = end_i;
        end else if (acc_ext > CpMax) begin
          burst_o.status = 1'b1;
          burst_o.done   = 1'b1;
          drop_d         = !end_i;
        end else begin
          burst_o.data[0]  = {HiSurPfx, supp[19:18]};
          burst_o.data[1]  = supp[17:10];
          burst_o.data[2]  = {LoSurPfx, supp[9:8]};
          burst_o.data[3]  = supp[7:0];
          burst_o.last_idx = IdxW'(3);
          burst_o.done     = end_i;
        end
      end else if (end_i) begin
        // truncated sequence
        has_result_o   = 1'b1;
        burst_o.status = 1'b1;
        burst_o.done   = 1'b1;
        pend_d         = 2'd0;
        acc_d          = '0;
      end else begin
        acc_d  = acc_ext;
        pend_d = pend_dec;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 2'd0;
      acc_q  <= '0;
      drop_q <= 1'b0;
    end else if (step_i) begin
      pend_q <= pend_d;
      acc_q  <= acc_d;
      drop_q <= drop_d;
    end
  end

endmodule

// ===== src/u8u16_serializer.sv =====
module u8u16_serializer
  import u8u16_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  burst_t           burst_i,
  output logic             free_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [ByteW-1:0] out_byte_o,
  output logic             status_o,
  output logic             run_last_o,
  output logic             string_done_o
);

  logic            valid_q;
  logic [IdxW-1:0] idx_q;
  burst_t          burst_q;
  logic            fire;

  assign out_valid_o   = valid_q;
  assign out_byte_o    = burst_q.data[idx_q];
  assign status_o      = burst_q.status;
  assign run_last_o    = (idx_q == burst_q.last_idx);
  assign string_done_o = burst_q.done && run_last_o;

  assign fire   = valid_q && out_ready_i;
  // register is free when empty or as the final beat of the burst leaves
  assign free_o = !valid_q || (fire && run_last_o);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else if (load_i) begin
      valid_q <= 1'b1;
      idx_q   <= '0;
    end else if (fire) begin
      if (run_last_o) begin
        valid_q <= 1'b0;
      end else begin
        idx_q <= idx_q + IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      burst_q <= burst_i;
    end
  end

endmodule

// ===== src/utf8_to_utf16be_transcoder_core.sv =====
// Channel | Direction | Handshake             | Payload
// input   | in        | in_valid_i/in_ready_o | in_byte_i, string_end_i
// output  | out       | out_valid_o/out_ready_i | out_byte_o, status_o, run_last_o,
//         |           |                       | string_done_o
//
// One input byte is registered, then decoded and its beats (0, 1, 2 or 4) loaded into
// the burst register once it is free; it sends one beat per cycle unless stalled.
// An ASCII byte therefore gives two beats, a supplementary code point four; a new byte
// is decoded only once the burst register is free, so its beat count sets the rate.
// Reset (rst_ni low, async) clears the decoder state and all valid flags.
// A stalled output holds the burst; the input register fills and in_ready_o drops.
module utf8_to_utf16be_transcoder_core
  import u8u16_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [ByteW-1:0] in_byte_i,
  input  logic             string_end_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [ByteW-1:0] out_byte_o,
  output logic             status_o,
  output logic             run_last_o,
  output logic             string_done_o
);

  logic             in_valid_q;
  logic [ByteW-1:0] in_byte_q;
  logic             in_end_q;
  logic             step;
  logic             free;
  logic             has_result;
  burst_t           burst;

  assign step       = in_valid_q && free;
  assign in_ready_o = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q <= in_byte_i;
      in_end_q  <= string_end_i;
    end
  end

  u8u16_decode u_decode (
    .clk_i,
    .rst_ni,
    .step_i       (step),
    .byte_i       (in_byte_q),
    .end_i        (in_end_q),
    .has_result_o (has_result),
    .burst_o      (burst)
  );

  u8u16_serializer u_serializer (
    .clk_i,
    .rst_ni,
    .load_i        (step && has_result),
    .burst_i       (burst),
    .free_o        (free),
    .out_valid_o,
    .out_ready_i,
    .out_byte_o,
    .status_o,
    .run_last_o,
    .string_done_o
  );

endmodule

// ===== src/u8u16_checker.sv =====
module u8u16_checker
  import u8u16_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input logic [ByteW-1:0] out_byte_o,
  input logic             status_o,
  input logic             run_last_o,
  input logic             string_done_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_byte_o))
    else $error("output byte changed while stalled");

  a_err_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> out_byte_o == '0 && run_last_o && string_done_o)
    else $error("error beat malformed");

  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && string_done_o |-> run_last_o)
    else $error("string end flagged before last beat of a byte");

  a_burst_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !run_last_o |=> out_valid_o && !status_o)
    else $error("burst interrupted");

endmodule

bind utf8_to_utf16be_transcoder_core u8u16_checker u_checker (
  .clk_i,
  .rst_ni,
  .out_valid_o,
  .out_ready_i,
  .out_byte_o,
  .status_o,
  .run_last_o,
  .string_done_o
);
